@@ hw/rtl/mar_pkg.sv @@
// shared widths, register map, reset values and types of the ramp limiter
package mar_pkg;

   // word and register widths
   localparam int unsigned LEVEL_W = 32;
   localparam int unsigned STEP_W  = 31;
   localparam int unsigned BAND_W  = 16;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned WIDE_W  = LEVEL_W + 2;

   // register map, indexed by paddr[3:2]
   localparam logic [1:0] REG_RISE_STEP = 2'd0;
   localparam logic [1:0] REG_FALL_STEP = 2'd1;
   localparam logic [1:0] REG_HOLD_BAND = 2'd2;

   // register reset values (one unit per tick, deadband about 0.0001)
   localparam logic [STEP_W-1:0] RISE_STEP_RST = STEP_W'(65536);
   localparam logic [STEP_W-1:0] FALL_STEP_RST = STEP_W'(65536);
   localparam logic [BAND_W-1:0] HOLD_BAND_RST = BAND_W'(7);

   // rate settings handed from the register block to the step logic
   typedef struct packed {
      logic [STEP_W-1:0] rise_step;
      logic [STEP_W-1:0] fall_step;
      logic [BAND_W-1:0] hold_band;
   } mar_cfg_type;

endpackage

@@ hw/rtl/mar_csr.sv @@
// configuration registers of the ramp limiter behind an apb-style port
module mar_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mar_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [mar_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [mar_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output mar_pkg::mar_cfg_type          cfg
);
   import mar_pkg::*;

   logic [STEP_W-1:0] rise_step_ff, rise_step_in;
   logic [STEP_W-1:0] fall_step_ff, fall_step_in;
   logic [BAND_W-1:0] hold_band_ff, hold_band_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // write decode, upper register bits dropped
   always_comb begin
      rise_step_in = rise_step_ff;
      fall_step_in = fall_step_ff;
      hold_band_in = hold_band_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_RISE_STEP: rise_step_in = csr_pwdata[STEP_W-1:0];
            REG_FALL_STEP: fall_step_in = csr_pwdata[STEP_W-1:0];
            REG_HOLD_BAND: hold_band_in = csr_pwdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_step_ff <= RISE_STEP_RST;
         fall_step_ff <= FALL_STEP_RST;
         hold_band_ff <= HOLD_BAND_RST;
      end else begin
         rise_step_ff <= rise_step_in;
         fall_step_ff <= fall_step_in;
         hold_band_ff <= hold_band_in;
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         REG_RISE_STEP: csr_prdata = DATA_W'(rise_step_ff);
         REG_FALL_STEP: csr_prdata = DATA_W'(fall_step_ff);
         REG_HOLD_BAND: csr_prdata = DATA_W'(hold_band_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.rise_step = rise_step_ff;
   assign cfg.fall_step = fall_step_ff;
   assign cfg.hold_band = hold_band_ff;

endmodule

@@ hw/rtl/mar_ingress.sv @@
// input register of the ramp limiter, holds one target word
module mar_ingress (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [mar_pkg::LEVEL_W-1:0] req_target,
   input  logic                              take,
   output logic                              hold_valid,
   output logic signed [mar_pkg::LEVEL_W-1:0] hold_target
);
   import mar_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [LEVEL_W-1:0] target_ff, target_in;
   logic                      accept;

   // refuse a word only while the held one cannot move on
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in  = accept || (valid_ff && !take);
      target_in = accept ? req_target : target_ff;
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      target_ff <= target_in;
   end

   assign hold_valid  = valid_ff;
   assign hold_target = target_ff;

endmodule

@@ hw/rtl/mar_step.sv @@
// one ramp step: picks the rate and direction, adds, clamps at the target
module mar_step (
   input  logic signed [mar_pkg::LEVEL_W-1:0] level,
   input  logic signed [mar_pkg::LEVEL_W-1:0] target,
   input  mar_pkg::mar_cfg_type              cfg,
   output logic signed [mar_pkg::LEVEL_W-1:0] level_next
);
   import mar_pkg::*;

   logic signed [WIDE_W-1:0] c_w, t_w, diff, step_w, sum;
   logic        [WIDE_W-1:0] mag_c, mag_t, mag_d;
   logic                     c_pos, c_neg, t_pos, t_neg;
   logic                     grows, shrinks, in_band;
   logic                     move, up, use_rise;

   // widen so no sum can overflow
   assign c_w  = WIDE_W'(level);
   assign t_w  = WIDE_W'(target);
   assign diff = t_w - c_w;

   assign mag_c = (c_w  < 0) ? $unsigned(-c_w)  : $unsigned(c_w);
   assign mag_t = (t_w  < 0) ? $unsigned(-t_w)  : $unsigned(t_w);
   assign mag_d = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);

   assign c_pos   = !level[LEVEL_W-1] && (level != '0);
   assign c_neg   = level[LEVEL_W-1];
   assign t_pos   = !target[LEVEL_W-1] && (target != '0);
   assign t_neg   = target[LEVEL_W-1];
   assign grows   = mag_t > mag_c;
   assign shrinks = mag_t < mag_c;
   assign in_band = mag_d <= WIDE_W'(cfg.hold_band);

   // rule priority: deadband, growth up, growth down, fall down, fall up
   always_comb begin
      move     = 1'b1;
      up       = 1'b1;
      use_rise = 1'b1;
      if (in_band) begin
         move = 1'b0;
      end else if (grows && !c_neg && t_pos) begin
         up       = 1'b1;
         use_rise = 1'b1;
      end else if (grows && !c_pos && t_neg) begin
         up       = 1'b0;
         use_rise = 1'b1;
      end else if ((c_pos && t_neg) || (shrinks && !t_neg && c_pos)) begin
         up       = 1'b0;
         use_rise = 1'b0;
      end else if ((c_neg && t_pos) || (shrinks && !t_pos && c_neg)) begin
         up       = 1'b1;
         use_rise = 1'b0;
      end else begin
         move = 1'b0;
      end
   end

   // single add or subtract, then clamp so the target is never passed
   assign step_w = use_rise ? WIDE_W'(cfg.rise_step) : WIDE_W'(cfg.fall_step);
   assign sum    = up ? (c_w + step_w) : (c_w - step_w);

   always_comb begin
      if (!move) begin
         level_next = level;
      end else if (up) begin
         level_next = (sum > t_w) ? target : sum[LEVEL_W-1:0];
      end else begin
         level_next = (sum < t_w) ? target : sum[LEVEL_W-1:0];
      end
   end

endmodule

@@ hw/rtl/magnitude_aware_ramp_limiter_unit.sv @@
// top level of the asymmetric ramp limiter: input register, step logic, level register
// Each accepted target word moves the stored Q16.16 level one step toward it, by rise_step
// while the magnitude grows with the sign kept and by fall_step while it shrinks or must cross
// zero, never past the target and not at all inside hold_band; the new level is returned as
// one result word. A word is taken every cycle unless the result side stalls; each accepted
// word waits in the input register and is stepped into the level register once the result
// slot is free, the level register feeding back through the step adder and clamp. The level
// register doubles as the result register and clears to zero on reset; registers sit at byte
// addresses 0, 4 and 8 and may be written only while the unit is idle.
module magnitude_aware_ramp_limiter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mar_pkg::LEVEL_W-1:0] req_target,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mar_pkg::LEVEL_W-1:0] rsp_level_out,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mar_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [mar_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [mar_pkg::DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import mar_pkg::*;

   mar_cfg_type               cfg;
   logic                      hold_valid;
   logic signed [LEVEL_W-1:0] hold_target;
   logic signed [LEVEL_W-1:0] level_next;
   logic                      out_free, fire;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;

   mar_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mar_ingress u_ingress (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_target  (req_target),
      .take        (fire),
      .hold_valid  (hold_valid),
      .hold_target (hold_target)
   );

   mar_step u_step (
      .level      (level_ff),
      .target     (hold_target),
      .cfg        (cfg),
      .level_next (level_next)
   );

   // a held word steps the level once the result slot is free
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = hold_valid && out_free;

   always_comb begin
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      level_in     = fire ? level_next : level_ff;
   end

   // level and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level_out = level_ff;

   // level only moves when a word is stepped
   a_level_holds : assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(level_ff))
      else $error("level changed without a stepped word");

   // every stepped word yields a result
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("stepped word gave no result");

   // new level lies between the old level and the target
   a_no_overshoot : assert property (@(posedge clock) disable iff (reset)
      fire |=> (((level_ff >= $past(level_ff)) && (level_ff <= $past(hold_target)))
             || ((level_ff <= $past(level_ff)) && (level_ff >= $past(hold_target)))))
      else $error("level passed the target");

   // input refused only while the input register is occupied
   a_stall_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> hold_valid)
      else $error("input stalled with empty input register");

endmodule
